// ===== sv/j7s_pkg.sv =====
`default_nettype none

package j7s_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SIZE = 2'd0,
        REG_Y_SIZE = 2'd1,
        REG_Z_SIZE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] x;
        logic [CFG_W-1:0] y;
        logic [CFG_W-1:0] z;
    } size_cfg_t;

    // Token that travels beside the data of one window through the datapath.
    typedef struct packed {
        logic valid;
        logic block_end;
    } tok_t;

    // Neighbor weight 5461/65536 (about 1/12) and centre weight 32768/65536.
    localparam int                       WEIGHT_W     = 14;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT     = 14'sd5461;
    localparam int                       CENTRE_SHIFT = 15;
    localparam int                       FRAC_BITS    = 16;
    localparam int                       ROUND_ADD    = 32768;

endpackage

`default_nettype wire

// ===== sv/j7s_delay.sv =====
`default_nettype none

module j7s_delay #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             clear,
    input  wire logic             shift,
    input  wire logic [AW-1:0]    last,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic [WIDTH-1:0] dout_reg;

    // The circular buffer runs over last+1 entries; with the output register
    // the delay is last+2 shifts.
    always_comb begin
        ptr_next = ptr_reg;
        if (clear) begin
            ptr_next = '0;
        end else if (shift) begin
            ptr_next = (ptr_reg == last) ? '0 : ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            dout_reg     <= mem[ptr_reg];
            mem[ptr_reg] <= din;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

// ===== sv/j7s_window.sv =====
`default_nettype none

module j7s_window #(
    parameter int SAMPLE_BITS = 32,
    parameter int SIZE_MAX    = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire j7s_pkg::size_cfg_t     sizes,
    input  wire logic                   cfg_clear,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                   win_ready,
    output j7s_pkg::tok_t               win_tok,
    output logic      [SAMPLE_BITS-1:0] tap_xp,
    output logic      [SAMPLE_BITS-1:0] tap_xm,
    output logic      [SAMPLE_BITS-1:0] tap_yp,
    output logic      [SAMPLE_BITS-1:0] tap_ym,
    output logic      [SAMPLE_BITS-1:0] tap_zp,
    output logic      [SAMPLE_BITS-1:0] tap_zm,
    output logic      [SAMPLE_BITS-1:0] tap_ctr
);

    import j7s_pkg::*;

    localparam int POS_W       = $clog2(SIZE_MAX + 2);
    localparam int MW          = 2 * POS_W;
    localparam int PLANE_DEPTH = (SIZE_MAX + 1) * (SIZE_MAX + 2) - 1;
    localparam int LINE_DEPTH  = SIZE_MAX;
    localparam int PAW         = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
    localparam int LAW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [POS_W-1:0] nx, ny, nz;
    logic [POS_W-1:0] nx1, ny1, nz1;
    logic [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [POS_W-1:0] px_next, py_next, pz_next;
    logic [MW-1:0]    ny_m, nz_m, plane_m;
    logic [PAW-1:0]   last_plane;
    logic [LAW-1:0]   last_line;
    logic             accept;
    logic             produce;
    logic             at_end;
    tok_t             tok_reg;
    tok_t             tok_next;

    logic [SAMPLE_BITS-1:0] xp_reg;
    logic [SAMPLE_BITS-1:0] ctr_reg;
    logic [SAMPLE_BITS-1:0] zm_reg;
    logic [SAMPLE_BITS-1:0] yp_w, zp_w, ym_w, xm_w;

    assign nx  = POS_W'(sizes.x);
    assign ny  = POS_W'(sizes.y);
    assign nz  = POS_W'(sizes.z);
    assign nx1 = nx + POS_W'(1);
    assign ny1 = ny + POS_W'(1);
    assign nz1 = nz + POS_W'(1);

    // With P = (ny+2)(nz+2) and Z = nz+2 the taps sit at these delays:
    // y+1 at P-Z, z+1 at P-1, centre at P, z-1 at P+1, y-1 at P+Z, x-1 at 2P.
    assign ny_m       = MW'(ny) + MW'(1);
    assign nz_m       = MW'(nz) + MW'(2);
    assign plane_m    = ny_m * nz_m;
    assign last_plane = PAW'(plane_m - MW'(2));
    assign last_line  = LAW'(nz - POS_W'(1));

    assign s_ready = !tok_reg.valid || win_ready;
    assign accept  = s_valid && s_ready;

    assign produce = (px_reg >= POS_W'(2)) && (py_reg != '0) && (py_reg <= ny)
                  && (pz_reg != '0) && (pz_reg <= nz);
    assign at_end  = (px_reg == nx1) && (py_reg == ny) && (pz_reg == nz);

    always_comb begin
        px_next = px_reg;
        py_next = py_reg;
        pz_next = pz_reg;
        if (cfg_clear) begin
            px_next = '0;
            py_next = '0;
            pz_next = '0;
        end else if (accept) begin
            if (pz_reg == nz1) begin
                pz_next = '0;
                if (py_reg == ny1) begin
                    py_next = '0;
                    px_next = (px_reg == nx1) ? '0 : px_reg + POS_W'(1);
                end else begin
                    py_next = py_reg + POS_W'(1);
                end
            end else begin
                pz_next = pz_reg + POS_W'(1);
            end
        end
    end

    always_comb begin
        tok_next = tok_reg;
        if (accept) begin
            tok_next.valid     = produce;
            tok_next.block_end = at_end;
        end else if (win_ready) begin
            tok_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
            tok_reg <= '0;
        end else begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            xp_reg  <= s_sample;
            ctr_reg <= zp_w;
            zm_reg  <= ctr_reg;
        end
    end

    j7s_delay #(.DEPTH(PLANE_DEPTH), .WIDTH(SAMPLE_BITS)) u_dly_yp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_clear),
        .shift   (accept),
        .last    (last_plane),
        .din     (xp_reg),
        .dout    (yp_w)
    );

    j7s_delay #(.DEPTH(LINE_DEPTH), .WIDTH(SAMPLE_BITS)) u_dly_zp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_clear),
        .shift   (accept),
        .last    (last_line),
        .din     (yp_w),
        .dout    (zp_w)
    );

    j7s_delay #(.DEPTH(LINE_DEPTH), .WIDTH(SAMPLE_BITS)) u_dly_ym (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_clear),
        .shift   (accept),
        .last    (last_line),
        .din     (zm_reg),
        .dout    (ym_w)
    );

    j7s_delay #(.DEPTH(PLANE_DEPTH), .WIDTH(SAMPLE_BITS)) u_dly_xm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_clear),
        .shift   (accept),
        .last    (last_plane),
        .din     (ym_w),
        .dout    (xm_w)
    );

    assign win_tok = tok_reg;
    assign tap_xp  = xp_reg;
    assign tap_xm  = xm_w;
    assign tap_yp  = yp_w;
    assign tap_ym  = ym_w;
    assign tap_zp  = zp_w;
    assign tap_zm  = zm_reg;
    assign tap_ctr = ctr_reg;

    a_clear_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_clear |=> (px_reg == '0 && py_reg == '0 && pz_reg == '0))
        else $error("scan position not cleared after a register write");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (px_reg <= nx1 && py_reg <= ny1 && pz_reg <= nz1))
        else $error("scan position beyond the padded block");

    a_hold_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_reg.valid && !win_ready) |-> !s_ready)
        else $error("input taken while a pending window is stalled");

endmodule

`default_nettype wire

// ===== sv/j7s_arith.sv =====
`default_nettype none

module j7s_arith #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire j7s_pkg::tok_t          in_tok,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] tap_xp,
    input  wire logic [SAMPLE_BITS-1:0] tap_xm,
    input  wire logic [SAMPLE_BITS-1:0] tap_yp,
    input  wire logic [SAMPLE_BITS-1:0] tap_ym,
    input  wire logic [SAMPLE_BITS-1:0] tap_zp,
    input  wire logic [SAMPLE_BITS-1:0] tap_zm,
    input  wire logic [SAMPLE_BITS-1:0] tap_ctr,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [SAMPLE_BITS-1:0] m_smoothed,
    output logic                        m_block_end
);

    import j7s_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int PAIR = SB + 1;
    localparam int SUMW = SB + 3;
    localparam int PW   = SUMW + WEIGHT_W;
    localparam int TW   = PW + 1;
    localparam int RW   = TW - FRAC_BITS;

    tok_t tok1_reg, tok2_reg, tok3_reg, tok4_reg;
    logic en1, en2, en3, en4;

    logic signed [PAIR-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [PAIR-1:0] sx_next, sy_next, sz_next;
    logic signed [SB-1:0]   c1_reg, c2_reg, c3_reg;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [TW-1:0]   t_sum;
    logic        [RW-1:0]   q;
    logic                   ovf;
    logic        [SB-1:0]   res_reg, res_next;

    // Each stage loads when it is empty or when the one after it moves; the last moves on m_ready.
    assign en4      = !tok4_reg.valid || m_ready;
    assign en3      = !tok3_reg.valid || en4;
    assign en2      = !tok2_reg.valid || en3;
    assign en1      = !tok1_reg.valid || en2;
    assign in_ready = en1;

    assign sx_next  = {tap_xp[SB-1], tap_xp} + {tap_xm[SB-1], tap_xm};
    assign sy_next  = {tap_yp[SB-1], tap_yp} + {tap_ym[SB-1], tap_ym};
    assign sz_next  = {tap_zp[SB-1], tap_zp} + {tap_zm[SB-1], tap_zm};
    assign sum_next = SUMW'(sx_reg) + SUMW'(sy_reg) + SUMW'(sz_reg);
    assign prod_next = PW'(sum_reg) * PW'(WEIGHT);

    // An arithmetic right shift of the rounded sum is the floor division.
    assign t_sum = (TW'(c3_reg) <<< CENTRE_SHIFT) + TW'(prod_reg) + TW'(ROUND_ADD);
    assign q     = t_sum[TW-1:FRAC_BITS];
    assign ovf   = !(&q[RW-1:SB-1]) && (|q[RW-1:SB-1]);

    always_comb begin
        res_next = q[SB-1:0];
        if (ovf) begin
            res_next = q[RW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
            tok4_reg <= '0;
        end else begin
            if (en1) begin
                tok1_reg <= in_tok;
            end
            if (en2) begin
                tok2_reg <= tok1_reg;
            end
            if (en3) begin
                tok3_reg <= tok2_reg;
            end
            if (en4) begin
                tok4_reg <= tok3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
            c1_reg <= tap_ctr;
        end
        if (en2) begin
            sum_reg <= sum_next;
            c2_reg  <= c1_reg;
        end
        if (en3) begin
            prod_reg <= prod_next;
            c3_reg   <= c2_reg;
        end
        if (en4) begin
            res_reg <= res_next;
        end
    end

    assign m_valid     = tok4_reg.valid;
    assign m_block_end = tok4_reg.block_end;
    assign m_smoothed  = res_reg;

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (tok1_reg.valid && tok2_reg.valid && tok3_reg.valid
                       && tok4_reg.valid && !m_ready))
        else $error("datapath blocks its input while a stage is empty");

endmodule

`default_nettype wire

// ===== sv/jacobi_7pt_stencil_3d.sv =====
`default_nettype none

// Seven-point 3D Jacobi stencil over a halo-padded block.
// Input: s_valid/s_ready/s_sample carry the padded block in raster order,
// x outermost and z fastest, (nx+2)(ny+2)(nz+2) signed Q15.16 samples.
// Output: m_valid/m_ready/m_smoothed/m_block_end carry one transaction per
// interior point, 0.5*centre + 5461/65536*(six neighbors), rounded and
// saturated; m_block_end marks the last interior point of the block.
// Sizes are written through cfg_we/cfg_index/cfg_data while idle; a write
// restarts the scan so that the next sample opens a new block.
// Throughput is one sample per cycle while the receiver keeps up. A point's
// result reaches the output once the edge that accepts its x+1 neighbor has
// loaded the window registers and the four datapath stages have followed.
// The window comes from two plane-length and two line-length circular
// buffers, each one read and one write per sample.
// Reset clears the scan position and all stage valid bits; buffer contents
// are not cleared, and no reset sweep is needed. When the receiver stalls
// the stages fill up and s_ready falls; nothing is dropped or repeated.
module jacobi_7pt_stencil_3d #(
    parameter int MAX_DIM     = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [j7s_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [j7s_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [SAMPLE_BITS-1:0]          s_sample,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [SAMPLE_BITS-1:0]          m_smoothed,
    output logic                                 m_block_end
);

    import j7s_pkg::*;

    localparam int SIZE_MAX = (MAX_DIM < 127) ? MAX_DIM : 127;
    localparam int SIZE_RST = (SIZE_MAX < 64) ? SIZE_MAX : 64;

    size_cfg_t        sizes_reg;
    size_cfg_t        sizes_next;
    logic [CFG_W-1:0] size_val;
    logic             cfg_clear;

    tok_t             win_tok;
    logic             win_ready;
    logic [SAMPLE_BITS-1:0] tap_xp, tap_xm, tap_yp, tap_ym, tap_zp, tap_zm, tap_ctr;

    always_comb begin
        size_val = cfg_data;
        if (cfg_data == '0) begin
            size_val = CFG_W'(1);
        end else if (cfg_data > CFG_W'(SIZE_MAX)) begin
            size_val = CFG_W'(SIZE_MAX);
        end
    end

    always_comb begin
        sizes_next = sizes_reg;
        cfg_clear  = 1'b0;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_X_SIZE: begin
                    sizes_next.x = size_val;
                    cfg_clear    = 1'b1;
                end
                REG_Y_SIZE: begin
                    sizes_next.y = size_val;
                    cfg_clear    = 1'b1;
                end
                REG_Z_SIZE: begin
                    sizes_next.z = size_val;
                    cfg_clear    = 1'b1;
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sizes_reg.x <= CFG_W'(SIZE_RST);
            sizes_reg.y <= CFG_W'(SIZE_RST);
            sizes_reg.z <= CFG_W'(SIZE_RST);
        end else begin
            sizes_reg <= sizes_next;
        end
    end

    j7s_window #(.SAMPLE_BITS(SAMPLE_BITS), .SIZE_MAX(SIZE_MAX)) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sizes     (sizes_reg),
        .cfg_clear (cfg_clear),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .win_ready (win_ready),
        .win_tok   (win_tok),
        .tap_xp    (tap_xp),
        .tap_xm    (tap_xm),
        .tap_yp    (tap_yp),
        .tap_ym    (tap_ym),
        .tap_zp    (tap_zp),
        .tap_zm    (tap_zm),
        .tap_ctr   (tap_ctr)
    );

    j7s_arith #(.SAMPLE_BITS(SAMPLE_BITS)) u_arith (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_tok      (win_tok),
        .in_ready    (win_ready),
        .tap_xp      (tap_xp),
        .tap_xm      (tap_xm),
        .tap_yp      (tap_yp),
        .tap_ym      (tap_ym),
        .tap_zp      (tap_zp),
        .tap_zm      (tap_zm),
        .tap_ctr     (tap_ctr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_smoothed  (m_smoothed),
        .m_block_end (m_block_end)
    );

endmodule

`default_nettype wire
